@@ design/lvm_pkg.sv @@
// Shared widths and constants for the look-at view matrix pipeline.
// Used by lvm_norm and look_at_view_matrix; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lvm_pkg;

	localparam int FIELD_W   = 32;
	localparam int IN_W      = 9 * FIELD_W;
	localparam int OUT_W     = 12 * FIELD_W;
	localparam int FRAC_BITS = 16;

	// normalizer: input magnitude up to 2^31, unit output within +-2^FRAC_BITS
	localparam int NORM_IW  = FIELD_W + 1;
	localparam int SQ_STEPS = 32;
	localparam int QW       = FRAC_BITS + 1;
	localparam int NW       = FIELD_W + FRAC_BITS;
	localparam int DW       = FRAC_BITS + 2;
	localparam int NORM_LAT = 2 + SQ_STEPS + 1 + QW + 1;

	// cross of unit forward and up hint, then range fit
	localparam int PW = DW + FIELD_W;
	localparam int CW = PW + 1;
	localparam int SW = $clog2(CW);
	localparam logic [CW-1:0] FIT_MAX = CW'(1) << 31;

	// true up and dot products
	localparam int UPW  = 2 * DW + 1;
	localparam int UW   = UPW - FRAC_BITS + 1;
	localparam int DOTW = UW + FIELD_W + 2;
	localparam int RW   = DOTW + 1 - FRAC_BITS;

endpackage

`default_nettype wire

@@ design/lvm_norm.sv @@
// Pipelined 3-vector normalizer: squares, sum, bit-per-stage square root,
// bit-per-stage rounded division of each component by the length.
// Depends on lvm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lvm_norm import lvm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic signed [NORM_IW-1:0] vec [3],
	output logic                      out_vld,
	output logic signed [DW-1:0]      unit [3]
);

	logic signed [2*NORM_IW-1:0] prod [3];
	logic        [NORM_IW-1:0]   magv [3];

	logic              vld_s1;
	logic [63:0]       sqr_s1 [3];
	logic [31:0]       mag_s1 [3];
	logic [2:0]        neg_s1;

	logic [SQ_STEPS:0] sq_vld_s2;
	logic [63:0]       sq_rem_s2  [SQ_STEPS+1];
	logic [31:0]       sq_root_s2 [SQ_STEPS+1];
	logic [31:0]       sq_mag_s2  [SQ_STEPS+1][3];
	logic [2:0]        sq_neg_s2  [SQ_STEPS+1];

	logic [63:0]       trial    [SQ_STEPS];
	logic [63:0]       rem_nxt  [SQ_STEPS];
	logic [31:0]       root_nxt [SQ_STEPS];

	logic [QW:0]       dv_vld_s3;
	logic [NW-1:0]     dv_rem_s3  [QW+1][3];
	logic [QW-1:0]     dv_q_s3    [QW+1][3];
	logic [31:0]       dv_len_s3  [QW+1];
	logic [QW:0]       dv_zero_s3;
	logic [2:0]        dv_neg_s3  [QW+1];

	logic [NW:0]       dcmp   [QW][3];
	logic [NW-1:0]     dv_rem_nxt [QW][3];
	logic [QW-1:0]     dv_q_nxt   [QW][3];

	logic              vld_s4;
	logic signed [DW-1:0] unit_s4 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = vec[i] * vec[i];
			magv[i] = vec[i][NORM_IW-1] ? NORM_IW'(-vec[i]) : NORM_IW'(vec[i]);
		end
	end

	always_comb begin
		for (int k = 0; k < SQ_STEPS; k++) begin
			trial[k] = (64'(sq_root_s2[k]) << (SQ_STEPS - k))
				+ (64'd1 << (2 * (SQ_STEPS - 1 - k)));
			if (sq_rem_s2[k] >= trial[k]) begin
				rem_nxt[k]  = sq_rem_s2[k] - trial[k];
				root_nxt[k] = sq_root_s2[k] | (32'd1 << (SQ_STEPS - 1 - k));
			end else begin
				rem_nxt[k]  = sq_rem_s2[k];
				root_nxt[k] = sq_root_s2[k];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < QW; j++) begin
			for (int i = 0; i < 3; i++) begin
				dcmp[j][i] = (NW+1)'(dv_len_s3[j]) << (QW - 1 - j);
				if ({1'b0, dv_rem_s3[j][i]} >= dcmp[j][i]) begin
					dv_rem_nxt[j][i] = dv_rem_s3[j][i] - dcmp[j][i][NW-1:0];
					dv_q_nxt[j][i]   = dv_q_s3[j][i] | (QW'(1) << (QW - 1 - j));
				end else begin
					dv_rem_nxt[j][i] = dv_rem_s3[j][i];
					dv_q_nxt[j][i]   = dv_q_s3[j][i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			sq_vld_s2 <= '0;
			dv_vld_s3 <= '0;
			vld_s4    <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_vld;
			sq_vld_s2 <= {sq_vld_s2[SQ_STEPS-1:0], vld_s1};
			dv_vld_s3 <= {dv_vld_s3[QW-1:0], sq_vld_s2[SQ_STEPS]};
			vld_s4    <= dv_vld_s3[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sqr_s1[i] <= prod[i][63:0];
				mag_s1[i] <= magv[i][31:0];
				neg_s1[i] <= vec[i][NORM_IW-1];
			end

			sq_rem_s2[0]  <= sqr_s1[0] + sqr_s1[1] + sqr_s1[2];
			sq_root_s2[0] <= '0;
			sq_mag_s2[0]  <= mag_s1;
			sq_neg_s2[0]  <= neg_s1;
			for (int k = 0; k < SQ_STEPS; k++) begin
				sq_rem_s2[k+1]  <= rem_nxt[k];
				sq_root_s2[k+1] <= root_nxt[k];
				sq_mag_s2[k+1]  <= sq_mag_s2[k];
				sq_neg_s2[k+1]  <= sq_neg_s2[k];
			end

			for (int i = 0; i < 3; i++) begin
				dv_rem_s3[0][i] <= (NW'(sq_mag_s2[SQ_STEPS][i]) << FRAC_BITS)
					+ NW'(sq_root_s2[SQ_STEPS] >> 1);
				dv_q_s3[0][i]   <= '0;
			end
			dv_len_s3[0]  <= sq_root_s2[SQ_STEPS];
			dv_zero_s3[0] <= (sq_root_s2[SQ_STEPS] == 32'd0);
			dv_neg_s3[0]  <= sq_neg_s2[SQ_STEPS];
			for (int j = 0; j < QW; j++) begin
				dv_rem_s3[j+1]  <= dv_rem_nxt[j];
				dv_q_s3[j+1]    <= dv_q_nxt[j];
				dv_len_s3[j+1]  <= dv_len_s3[j];
				dv_zero_s3[j+1] <= dv_zero_s3[j];
				dv_neg_s3[j+1]  <= dv_neg_s3[j];
			end

			for (int i = 0; i < 3; i++) begin
				if (dv_zero_s3[QW])
					unit_s4[i] <= '0;
				else if (dv_neg_s3[QW][i])
					unit_s4[i] <= -DW'(dv_q_s3[QW][i]);
				else
					unit_s4[i] <= DW'(dv_q_s3[QW][i]);
			end
		end
	end

	assign out_vld = vld_s4;
	assign unit    = unit_s4;

endmodule

`default_nettype wire

@@ design/look_at_view_matrix.sv @@
// Top level of the look-at view matrix pipeline: input register, two
// normalizers, cross products, range fit, dot products and saturation.
// Depends on lvm_pkg and lvm_norm.
//
// Use: one camera pose per transfer on the s_ channel; one 3x4 view matrix
// per transfer on the m_ channel, in the same order. All values are signed
// fixed point with FRAC_BITS fraction bits.
// Each normalizer computes a square root and then divides each component
// by the length.
// Throughput: one pose per cycle while m_tready stays high.
// Reset clears all valid bits; the pipeline comes up empty and s_tready high.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline holds and s_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module look_at_view_matrix import lvm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// forward_x, forward_y, forward_z, up_hint_x, up_hint_y, up_hint_z,
	// pos_x, pos_y, pos_z (32 bits each)
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// right_x, right_y, right_z, true_up_x, true_up_y, true_up_z,
	// back_x, back_y, back_z, shift_x, shift_y, shift_z (32 bits each)
	output logic [OUT_W-1:0] m_tdata
);

	localparam logic signed [UPW:0]  UP_HALF     = (UPW+1)'(1) << (FRAC_BITS - 1);
	localparam logic signed [UPW:0]  UP_HALF_M1  = UP_HALF - 1;
	localparam logic signed [DOTW:0] DOT_HALF    = (DOTW+1)'(1) << (FRAC_BITS - 1);
	localparam logic signed [DOTW:0] DOT_HALF_M1 = DOT_HALF - 1;
	localparam logic signed [RW:0]   SAT_MAX     = (RW+1)'(32'sh7fffffff);
	localparam logic signed [RW:0]   SAT_MIN     = ~SAT_MAX;

	logic en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14;
	logic n1_vld, n2_vld;

	logic signed [FIELD_W-1:0] fwd_s1 [3];
	logic signed [FIELD_W-1:0] hint_s1 [3];
	logic signed [FIELD_W-1:0] pos_s1 [3];
	logic signed [NORM_IW-1:0] n1_vec [3];
	logic signed [DW-1:0]      d_n1 [3];
	logic signed [FIELD_W-1:0] hint_dly_q [NORM_LAT][3];
	logic signed [FIELD_W-1:0] pos_dly_q  [NORM_LAT][3];

	logic signed [PW-1:0]      prd_s2 [6];
	logic signed [CW-1:0]      cr_s3 [3];
	logic [CW-1:0]             crm_s4 [3], crm_s5 [3], crm_s6 [3];
	logic [2:0]                crn_s4, crn_s5, crn_s6;
	logic [CW-1:0]             mx;
	logic [CW-1:0]             mx_s5;
	logic [SW-1:0]             sh;
	logic [SW-1:0]             sh_s6;
	logic [CW-1:0]             mfit [3];
	logic signed [NORM_IW-1:0] fitv [3];
	logic signed [NORM_IW-1:0] fit_s7 [3];

	logic signed [DW-1:0]      d_s2 [3], d_s3 [3], d_s4 [3], d_s5 [3], d_s6 [3], d_s7 [3];
	logic signed [FIELD_W-1:0] pos_s2 [3], pos_s3 [3], pos_s4 [3];
	logic signed [FIELD_W-1:0] pos_s5 [3], pos_s6 [3], pos_s7 [3];
	logic signed [DW-1:0]      d_dly_q    [NORM_LAT][3];
	logic signed [FIELD_W-1:0] pos2_dly_q [NORM_LAT][3];
	logic signed [DW-1:0]      rt_n2 [3];

	logic signed [2*DW-1:0]    pu_s8 [6];
	logic signed [DW-1:0]      rt_s8 [3], rt_s9 [3], rt_s10 [3];
	logic signed [DW-1:0]      rt_s11 [3], rt_s12 [3], rt_s13 [3];
	logic signed [DW-1:0]      d_s8 [3], d_s9 [3], d_s10 [3];
	logic signed [DW-1:0]      d_s11 [3], d_s12 [3], d_s13 [3];
	logic signed [FIELD_W-1:0] pos_s8 [3], pos_s9 [3], pos_s10 [3];
	logic signed [UPW-1:0]     ud_s9 [3];
	logic signed [UPW:0]       uadd [3];
	logic signed [UW-1:0]      up_s10 [3], up_s11 [3], up_s12 [3], up_s13 [3];

	logic signed [DOTW-1:0]    dpr_s11 [3], dpu_s11 [3], dpd_s11 [3];
	logic signed [DOTW-1:0]    dot_s12 [3];
	logic signed [DOTW:0]      dadd [3];
	logic signed [RW-1:0]      rnd_s13 [3];
	logic signed [RW:0]        nv [3];
	logic [FIELD_W-1:0]        shv [3];
	logic [OUT_W-1:0]          tdata_s14;

	assign en       = !vld_s14 || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s14;
	assign m_tdata  = tdata_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
		end else if (en) begin
			vld_s1  <= s_tvalid;
			vld_s2  <= n1_vld;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= n2_vld;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
		end
	end

	// unit forward
	always_comb begin
		for (int i = 0; i < 3; i++)
			n1_vec[i] = {fwd_s1[i][FIELD_W-1], fwd_s1[i]};
	end

	lvm_norm u_norm_fwd (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s1),
		.vec     (n1_vec),
		.out_vld (n1_vld),
		.unit    (d_n1)
	);

	// range fit of the cross product
	always_comb begin
		mx = crm_s4[0];
		if (crm_s4[1] > mx)
			mx = crm_s4[1];
		if (crm_s4[2] > mx)
			mx = crm_s4[2];
	end

	always_comb begin
		sh = '0;
		for (int s = CW - 1; s >= 0; s--) begin
			if ((mx_s5 >> s) <= FIT_MAX)
				sh = SW'(s);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mfit[i] = crm_s6[i] >> sh_s6;
			fitv[i] = crn_s6[i] ? -$signed({1'b0, mfit[i][31:0]})
				: $signed({1'b0, mfit[i][31:0]});
		end
	end

	lvm_norm u_norm_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s7),
		.vec     (fit_s7),
		.out_vld (n2_vld),
		.unit    (rt_n2)
	);

	// round to FRAC_BITS, halves away from zero
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			uadd[i] = (UPW+1)'(ud_s9[i])
				+ (ud_s9[i][UPW-1] ? UP_HALF_M1 : UP_HALF);
			dadd[i] = (DOTW+1)'(dot_s12[i])
				+ (dot_s12[i][DOTW-1] ? DOT_HALF_M1 : DOT_HALF);
		end
	end

	// negate the first two translations, then saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nv[i] = (i < 2) ? -(RW+1)'(rnd_s13[i]) : (RW+1)'(rnd_s13[i]);
			if (nv[i] > SAT_MAX)
				shv[i] = 32'h7fffffff;
			else if (nv[i] < SAT_MIN)
				shv[i] = 32'h80000000;
			else
				shv[i] = nv[i][FIELD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				fwd_s1[i]  <= s_tdata[FIELD_W*i +: FIELD_W];
				hint_s1[i] <= s_tdata[FIELD_W*(3+i) +: FIELD_W];
				pos_s1[i]  <= s_tdata[FIELD_W*(6+i) +: FIELD_W];
			end

			hint_dly_q[0] <= hint_s1;
			pos_dly_q[0]  <= pos_s1;
			for (int k = 1; k < NORM_LAT; k++) begin
				hint_dly_q[k] <= hint_dly_q[k-1];
				pos_dly_q[k]  <= pos_dly_q[k-1];
			end

			prd_s2[0] <= d_n1[1] * hint_dly_q[NORM_LAT-1][2];
			prd_s2[1] <= d_n1[2] * hint_dly_q[NORM_LAT-1][1];
			prd_s2[2] <= d_n1[2] * hint_dly_q[NORM_LAT-1][0];
			prd_s2[3] <= d_n1[0] * hint_dly_q[NORM_LAT-1][2];
			prd_s2[4] <= d_n1[0] * hint_dly_q[NORM_LAT-1][1];
			prd_s2[5] <= d_n1[1] * hint_dly_q[NORM_LAT-1][0];
			d_s2   <= d_n1;
			pos_s2 <= pos_dly_q[NORM_LAT-1];

			cr_s3[0] <= prd_s2[0] - prd_s2[1];
			cr_s3[1] <= prd_s2[2] - prd_s2[3];
			cr_s3[2] <= prd_s2[4] - prd_s2[5];
			d_s3   <= d_s2;
			pos_s3 <= pos_s2;

			for (int i = 0; i < 3; i++) begin
				crm_s4[i] <= cr_s3[i][CW-1] ? CW'(-cr_s3[i]) : CW'(cr_s3[i]);
				crn_s4[i] <= cr_s3[i][CW-1];
			end
			d_s4   <= d_s3;
			pos_s4 <= pos_s3;

			mx_s5  <= mx;
			crm_s5 <= crm_s4;
			crn_s5 <= crn_s4;
			d_s5   <= d_s4;
			pos_s5 <= pos_s4;

			sh_s6  <= sh;
			crm_s6 <= crm_s5;
			crn_s6 <= crn_s5;
			d_s6   <= d_s5;
			pos_s6 <= pos_s5;

			fit_s7 <= fitv;
			d_s7   <= d_s6;
			pos_s7 <= pos_s6;

			d_dly_q[0]    <= d_s7;
			pos2_dly_q[0] <= pos_s7;
			for (int k = 1; k < NORM_LAT; k++) begin
				d_dly_q[k]    <= d_dly_q[k-1];
				pos2_dly_q[k] <= pos2_dly_q[k-1];
			end

			pu_s8[0] <= rt_n2[1] * d_dly_q[NORM_LAT-1][2];
			pu_s8[1] <= rt_n2[2] * d_dly_q[NORM_LAT-1][1];
			pu_s8[2] <= rt_n2[2] * d_dly_q[NORM_LAT-1][0];
			pu_s8[3] <= rt_n2[0] * d_dly_q[NORM_LAT-1][2];
			pu_s8[4] <= rt_n2[0] * d_dly_q[NORM_LAT-1][1];
			pu_s8[5] <= rt_n2[1] * d_dly_q[NORM_LAT-1][0];
			rt_s8  <= rt_n2;
			d_s8   <= d_dly_q[NORM_LAT-1];
			pos_s8 <= pos2_dly_q[NORM_LAT-1];

			ud_s9[0] <= pu_s8[0] - pu_s8[1];
			ud_s9[1] <= pu_s8[2] - pu_s8[3];
			ud_s9[2] <= pu_s8[4] - pu_s8[5];
			rt_s9  <= rt_s8;
			d_s9   <= d_s8;
			pos_s9 <= pos_s8;

			for (int i = 0; i < 3; i++)
				up_s10[i] <= uadd[i][UPW:FRAC_BITS];
			rt_s10  <= rt_s9;
			d_s10   <= d_s9;
			pos_s10 <= pos_s9;

			for (int i = 0; i < 3; i++) begin
				dpr_s11[i] <= rt_s10[i] * pos_s10[i];
				dpu_s11[i] <= up_s10[i] * pos_s10[i];
				dpd_s11[i] <= d_s10[i] * pos_s10[i];
			end
			rt_s11 <= rt_s10;
			up_s11 <= up_s10;
			d_s11  <= d_s10;

			dot_s12[0] <= dpr_s11[0] + dpr_s11[1] + dpr_s11[2];
			dot_s12[1] <= dpu_s11[0] + dpu_s11[1] + dpu_s11[2];
			dot_s12[2] <= dpd_s11[0] + dpd_s11[1] + dpd_s11[2];
			rt_s12 <= rt_s11;
			up_s12 <= up_s11;
			d_s12  <= d_s11;

			for (int i = 0; i < 3; i++)
				rnd_s13[i] <= dadd[i][DOTW:FRAC_BITS];
			rt_s13 <= rt_s12;
			up_s13 <= up_s12;
			d_s13  <= d_s12;

			for (int i = 0; i < 3; i++) begin
				tdata_s14[FIELD_W*i +: FIELD_W]     <= FIELD_W'(rt_s13[i]);
				tdata_s14[FIELD_W*(3+i) +: FIELD_W] <= FIELD_W'(up_s13[i]);
				tdata_s14[FIELD_W*(6+i) +: FIELD_W] <= -FIELD_W'(d_s13[i]);
				tdata_s14[FIELD_W*(9+i) +: FIELD_W] <= shv[i];
			end
		end
	end

endmodule

`default_nettype wire

@@ verif/tb_look_at_view_matrix.sv @@
// Testbench for look_at_view_matrix: camera poses in, 3x4 view matrices out.
// A queued driver and a clocked monitor check every transfer against an in-bench predictor.
// Depends on lvm_pkg and the look_at_view_matrix RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb_look_at_view_matrix;
	import lvm_pkg::*;

	localparam int WATCHDOG = 20000;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	logic [IN_W-1:0]  pose_q[$];
	logic [OUT_W-1:0] matrix_q[$];
	int               errors = 0;
	bit               feed_done = 0;
	int               send_gap = 0;
	int               recv_gap = 0;
	int               hold_cycles = 0;
	int               quiet = 0;

	look_at_view_matrix dut (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [63:0] mag64(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint signed_of(logic [63:0] m, bit neg);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [63:0] root64(logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void unit_vec(input longint c[3], output longint o[3]);
		logic [63:0] s, len, q;
		s = 0;
		for (int i = 0; i < 3; i++) s += 64'(c[i] * c[i]);
		len = root64(s);
		for (int i = 0; i < 3; i++) begin
			if (len == 0) begin
				o[i] = 0;
			end else begin
				q = ((mag64(c[i]) << FRAC_BITS) + (len >> 1)) / len;
				o[i] = signed_of(q, c[i] < 0);
			end
		end
	endfunction

	function automatic longint round_frac(longint v);
		return signed_of((mag64(v) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS, v < 0);
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
		if (v < -64'sh80000000) return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic logic [OUT_W-1:0] view_matrix(logic [IN_W-1:0] pose);
		longint fwd[3], hint[3], pos[3], d[3], cr[3], rt[3], up[3];
		logic [63:0] mx;
		int sh;
		logic [OUT_W-1:0] r;
		for (int i = 0; i < 3; i++) begin
			fwd[i]  = longint'($signed(pose[i*32 +: 32]));
			hint[i] = longint'($signed(pose[(3+i)*32 +: 32]));
			pos[i]  = longint'($signed(pose[(6+i)*32 +: 32]));
		end
		unit_vec(fwd, d);
		cr[0] = d[1]*hint[2] - d[2]*hint[1];
		cr[1] = d[2]*hint[0] - d[0]*hint[2];
		cr[2] = d[0]*hint[1] - d[1]*hint[0];
		mx = 0;
		for (int i = 0; i < 3; i++) if (mag64(cr[i]) > mx) mx = mag64(cr[i]);
		sh = 0;
		while ((mx >> sh) > (64'd1 << 31)) sh++;
		for (int i = 0; i < 3; i++) cr[i] = signed_of(mag64(cr[i]) >> sh, cr[i] < 0);
		unit_vec(cr, rt);
		up[0] = round_frac(rt[1]*d[2] - rt[2]*d[1]);
		up[1] = round_frac(rt[2]*d[0] - rt[0]*d[2]);
		up[2] = round_frac(rt[0]*d[1] - rt[1]*d[0]);
		for (int i = 0; i < 3; i++) begin
			r[i*32 +: 32]     = rt[i][31:0];
			r[(3+i)*32 +: 32] = up[i][31:0];
			r[(6+i)*32 +: 32] = 32'(-d[i]);
		end
		r[9*32 +: 32]  = clamp32(-round_frac(rt[0]*pos[0] + rt[1]*pos[1] + rt[2]*pos[2]));
		r[10*32 +: 32] = clamp32(-round_frac(up[0]*pos[0] + up[1]*pos[1] + up[2]*pos[2]));
		r[11*32 +: 32] = clamp32(round_frac(d[0]*pos[0] + d[1]*pos[1] + d[2]*pos[2]));
		return r;
	endfunction

	function automatic logic [31:0] rand_comp(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			2: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
			default: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
		endcase
	endfunction

	function automatic logic [IN_W-1:0] make_pose(logic [31:0] fx, fy, fz, ux, uy, uz,
			px, py, pz);
		return {pz, py, px, uz, uy, ux, fz, fy, fx};
	endfunction

	initial begin
		logic [IN_W-1:0] p;
		logic [31:0] one, mn, mxv;
		one = 32'h00010000;
		mn  = 32'h80000000;
		mxv = 32'h7FFFFFFF;
		pose_q.push_back(make_pose(0, 0, 0, 0, one, 0, one, one, one));
		pose_q.push_back(make_pose(0, 0, -one, 0, one, 0, 0, 0, 0));
		pose_q.push_back(make_pose(0, 0, -one, 0, one, 0, one*5, -one*3, one*7));
		pose_q.push_back(make_pose(0, one, 0, 0, one, 0, one, one, one));
		pose_q.push_back(make_pose(one, 0, 0, 0, 0, 0, one, one, one));
		pose_q.push_back(make_pose(one, one, one, -one, -one, -one, one, 2, 3));
		pose_q.push_back(make_pose(mn, mn, mn, mxv, 0, mn, mxv, mxv, mxv));
		pose_q.push_back(make_pose(mxv, mxv, mxv, mn, mxv, 0, mn, mn, mn));
		pose_q.push_back(make_pose(mn, 0, 0, 0, mn, 0, mxv, mn, mxv));
		pose_q.push_back(make_pose(1, 0, 0, 0, 0, 1, 1, 1, 1));
		pose_q.push_back(make_pose(one, 0, 0, 0, mxv, mxv, mxv, mxv, mxv));
		pose_q.push_back(make_pose(-one, 0, 0, 0, mn, mxv, mn, mn, mn));
		pose_q.push_back(make_pose(mxv, 1, -1, 1, mxv, 0, mxv, mn, 0));
		pose_q.push_back(make_pose(-1, -1, -1, -1, -1, -1, -1, -1, -1));
		for (int n = 0; n < 950; n++) begin
			int m;
			m = $urandom_range(0, 9);
			for (int k = 0; k < 9; k++)
				p[k*32 +: 32] = rand_comp(m < 4 ? 0 : m < 7 ? 1 : m < 9 ? 2 : $urandom_range(0, 3));
			if ($urandom_range(0, 19) == 0) p[0 +: 96] = '0;
			if ($urandom_range(0, 19) == 0) p[96 +: 96] = p[0 +: 96];
			pose_q.push_back(p);
		end
		feed_done = 1;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver: each pose held until its transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				matrix_q.push_back(view_matrix(s_tdata));
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					s_tvalid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pose_q.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pose_q.pop_front();
					send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		logic [OUT_W-1:0] want;
		if (!arst_n) begin
			m_tready    <= 1'b0;
			recv_gap    <= 0;
			hold_cycles <= 300;
		end else begin
			if (m_tvalid && m_tready) begin
				if (matrix_q.size() == 0) begin
					$display("%0t: unexpected matrix %h", $time, m_tdata);
					errors++;
				end else begin
					want = matrix_q.pop_front();
					for (int i = 0; i < 12; i++)
						if (want[i*32 +: 32] !== m_tdata[i*32 +: 32]) begin
							$display("%0t: field %0d expected %h actual %h", $time, i,
								want[i*32 +: 32], m_tdata[i*32 +: 32]);
							errors++;
						end
				end
			end
			if (hold_cycles > 0 && matrix_q.size() > 40) begin
				m_tready    <= 1'b0;
				hold_cycles <= hold_cycles - 1;
			end else if (recv_gap > 0) begin
				m_tready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				m_tready <= 1'b1;
				if (m_tvalid && m_tready)
					recv_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > WATCHDOG) begin
			$display("look_at_view_matrix regression: fail");
			$finish;
		end
	end

	initial begin
		@(posedge arst_n);
		wait (feed_done && pose_q.size() == 0 && !s_tvalid && matrix_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && matrix_q.size() == 0)
			$display("look_at_view_matrix regression: pass");
		else
			$display("look_at_view_matrix regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
design/lvm_pkg.sv
design/lvm_norm.sv
design/look_at_view_matrix.sv
verif/tb_look_at_view_matrix.sv
